FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the buddy page allocator.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define BPA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold at a rising edge of clk outside reset.
`define BPA_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/bpa_pkg.sv
// Package of the buddy page allocator: beat types, node and error codes, FSM states.
// Depends on nothing; used by bpa_node_mem and buddy_page_allocator_top.
package bpa_pkg;

	localparam int TOP_ORDER_DEF    = 13;
	localparam int PAGE_SHIFT_DEF   = 12;
	localparam int HEADER_BYTES_DEF = 8;

	localparam logic [31:0] BASE_RESET = 32'hD000_0000;
	localparam logic        MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_UNUSED = 2'd0,
		ST_FREE   = 2'd1,
		ST_ALLOC  = 2'd2,
		ST_SPLIT  = 2'd3
	} node_st_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_SIZE  = 2'd1,
		ERR_NOMEM = 2'd2,
		ERR_FREE  = 2'd3
	} err_t;

	typedef struct packed {
		logic        mode;
		logic [25:0] size_bytes;
		logic [31:0] free_pointer;
		logic [3:0]  free_order;
	} req_t;

	typedef struct packed {
		logic [31:0] user_pointer;
		logic [3:0]  block_order;
		err_t        error_code;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SEEK_RD,
		S_SEEK_CHK,
		S_BACK,
		S_SPLIT_A,
		S_SPLIT_B,
		S_MARK,
		S_FREE_RD,
		S_FREE_CHK,
		S_MRG_RD,
		S_MRG_CHK,
		S_MRG_B,
		S_MRG_C
	} fsm_t;

endpackage

FILE: rtl/bpa_node_mem.sv
// Node status memory of the buddy tree: one write port, one read port, registered read.
// Depends on bpa_pkg for the node status type.
module bpa_node_mem import bpa_pkg::*; #(
	parameter int AW = TOP_ORDER_DEF + 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  node_st_t      wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output node_st_t      rdata
);

	localparam int DEPTH = 1 << AW;

	node_st_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/buddy_page_allocator_top.sv
// Channel  | Ports                               | Handshake
// request  | start, busy, item (req_t)           | taken at start && !busy
// result   | done, result (rsp_t)                | one cycle, marked by done
// config   | psel, penable, pwrite, paddr, pwdata| APB write, pready tied high
// After reset a clearing pass writes all 2^(TOP_ORDER+1) nodes, one per cycle, with busy high.
// An allocate searches down from the root, backtracks past full subtrees and splits a free block to the target order.
// A free marks its block free, then merges it with its free buddy level by level, at most up to the root.
// A request refused at decode, and a free of a node that is not allocated, end without writing the tree.
// Results cannot be stalled; the next request is taken in the cycle its predecessor's beat shows.
// Top level of the buddy page allocator; depends on bpa_pkg, bpa_node_mem, assert_macros.svh.
`include "assert_macros.svh"
module buddy_page_allocator_top import bpa_pkg::*; #(
	parameter int TOP_ORDER    = TOP_ORDER_DEF,
	parameter int PAGE_SHIFT   = PAGE_SHIFT_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        item,
	output logic        done,
	output rsp_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NW = TOP_ORDER + 1;
	localparam int OW = $clog2(TOP_ORDER + 2);
	localparam logic [63:0] POOL_BYTES = 64'(1) << (PAGE_SHIFT + TOP_ORDER);
	localparam logic [63:0] HDR = 64'(HEADER_BYTES);
	localparam logic [NW-1:0] ROOT = NW'(1);

	fsm_t state_q, state_d;
	logic [31:0]   base_q;
	req_t          item_q;
	logic [NW-1:0] n_q, clr_q;
	logic [OW-1:0] lvl_q, tgt_q;
	rsp_t          res_q;
	logic          done_q;

	logic          mem_we, mem_re;
	logic [NW-1:0] mem_waddr, mem_raddr;
	node_st_t      mem_wdata, mem_rdata;
	logic          fin;
	rsp_t          fin_res;

	// Decode of the captured request.
	logic [63:0]   size64, need64, off64, blk_mask;
	logic [31:0]   off32;
	logic [OW-1:0] tgt_cnt;
	logic          alloc_bad, free_null, free_bad;
	logic [NW-1:0] free_node;
	logic [63:0]   mark_off;
	logic [31:0]   mark_ptr;
	logic [NW-1:0] buddy;

	assign buddy = {n_q[NW-1:1], ~n_q[0]};

	always_comb begin
		size64 = {38'd0, item_q.size_bytes};
		need64 = size64 + HDR;
		tgt_cnt = '0;
		for (int t = 0; t <= TOP_ORDER; t++) begin
			if (need64 > (64'(1) << (PAGE_SHIFT + t))) begin
				tgt_cnt = tgt_cnt + OW'(1);
			end
		end
		alloc_bad = (size64 == 64'd0) || (size64 > POOL_BYTES) ||
			(int'(tgt_cnt) > TOP_ORDER);

		off32 = item_q.free_pointer - 32'(HEADER_BYTES) - base_q;
		off64 = {32'd0, off32};
		blk_mask = (64'(1) << (PAGE_SHIFT + int'(item_q.free_order))) - 64'd1;
		free_null = (item_q.free_pointer == 32'd0);
		free_bad = (int'(item_q.free_order) > TOP_ORDER) || (off64 >= POOL_BYTES) ||
			((off64 & blk_mask) != 64'd0);
		free_node = (NW'(1) << (TOP_ORDER - int'(item_q.free_order))) +
			NW'(off64 >> (PAGE_SHIFT + int'(item_q.free_order)));

		// The node's depth bit lands on the pool size bit and is masked off.
		mark_off = (64'(n_q) << (PAGE_SHIFT + int'(tgt_q))) & (POOL_BYTES - 64'd1);
		mark_ptr = 32'({32'd0, base_q} + mark_off + HDR);
	end

	bpa_node_mem #(.AW(NW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == '1) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (item_q.mode == MODE_FREE) begin
					state_d = (free_null || free_bad) ? S_IDLE : S_FREE_RD;
				end else begin
					state_d = alloc_bad ? S_IDLE : S_SEEK_RD;
				end
			end
			S_SEEK_RD: state_d = S_SEEK_CHK;
			S_SEEK_CHK: begin
				if (mem_rdata == ST_FREE) begin
					state_d = (lvl_q > tgt_q) ? S_SPLIT_A : S_MARK;
				end else if (mem_rdata == ST_SPLIT && lvl_q > tgt_q) begin
					state_d = S_SEEK_RD;
				end else begin
					state_d = S_BACK;
				end
			end
			S_BACK: begin
				if (n_q == ROOT) state_d = S_IDLE;
				else if (!n_q[0]) state_d = S_SEEK_RD;
			end
			S_SPLIT_A: state_d = S_SPLIT_B;
			S_SPLIT_B: state_d = (lvl_q - OW'(1) > tgt_q) ? S_SPLIT_A : S_MARK;
			S_MARK: state_d = S_IDLE;
			S_FREE_RD: state_d = S_FREE_CHK;
			S_FREE_CHK: state_d = (mem_rdata == ST_ALLOC) ? S_MRG_RD : S_IDLE;
			S_MRG_RD: state_d = (n_q == ROOT) ? S_IDLE : S_MRG_CHK;
			S_MRG_CHK: state_d = (mem_rdata == ST_FREE) ? S_MRG_B : S_IDLE;
			S_MRG_B: state_d = S_MRG_C;
			S_MRG_C: state_d = S_MRG_RD;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = n_q;
		mem_wdata = ST_UNUSED;
		mem_re = 1'b0;
		mem_raddr = n_q;
		fin = 1'b0;
		fin_res = '{user_pointer: 32'd0, block_order: 4'd0, error_code: ERR_OK};
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = (clr_q == ROOT) ? ST_FREE : ST_UNUSED;
			end
			S_DECODE: begin
				if (item_q.mode == MODE_FREE) begin
					if (free_null) begin
						fin = 1'b1;
					end else if (free_bad) begin
						fin = 1'b1;
						fin_res.error_code = ERR_FREE;
					end
				end else if (alloc_bad) begin
					fin = 1'b1;
					fin_res.error_code = ERR_SIZE;
				end
			end
			S_SEEK_RD, S_FREE_RD: mem_re = 1'b1;
			S_BACK: begin
				if (n_q == ROOT) begin
					fin = 1'b1;
					fin_res.error_code = ERR_NOMEM;
				end
			end
			S_SPLIT_A: begin
				mem_we = 1'b1;
				mem_wdata = ST_SPLIT;
			end
			S_SPLIT_B: begin
				mem_we = 1'b1;
				mem_waddr = {n_q[NW-2:0], 1'b1};
				mem_wdata = ST_FREE;
			end
			S_MARK: begin
				mem_we = 1'b1;
				mem_wdata = ST_ALLOC;
				fin = 1'b1;
				fin_res.user_pointer = mark_ptr;
				fin_res.block_order = 4'(tgt_q);
			end
			S_FREE_CHK: begin
				if (mem_rdata == ST_ALLOC) begin
					mem_we = 1'b1;
					mem_wdata = ST_FREE;
				end else begin
					fin = 1'b1;
					fin_res.error_code = ERR_FREE;
				end
			end
			S_MRG_RD: begin
				if (n_q == ROOT) begin
					fin = 1'b1;
				end else begin
					mem_re = 1'b1;
					mem_raddr = buddy;
				end
			end
			S_MRG_CHK: begin
				if (mem_rdata == ST_FREE) begin
					mem_we = 1'b1;
				end else begin
					fin = 1'b1;
				end
			end
			S_MRG_B: begin
				mem_we = 1'b1;
				mem_waddr = buddy;
			end
			S_MRG_C: begin
				mem_we = 1'b1;
				mem_wdata = ST_FREE;
			end
			default: ;
		endcase
		// A successful free echoes the pointer and order.
		if (fin && item_q.mode == MODE_FREE && fin_res.error_code == ERR_OK && !free_null) begin
			fin_res.user_pointer = item_q.free_pointer;
			fin_res.block_order = item_q.free_order;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			base_q <= BASE_RESET;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= fin;
			if (state_q == S_CLEAR) clr_q <= clr_q + NW'(1);
			if (psel && penable && pwrite && paddr == 2'd0) base_q <= pwdata;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) res_q <= fin_res;
		case (state_q)
			S_IDLE: begin
				if (start) item_q <= item;
			end
			S_DECODE: begin
				n_q <= (item_q.mode == MODE_FREE) ? free_node : ROOT;
				lvl_q <= OW'(TOP_ORDER);
				tgt_q <= tgt_cnt;
			end
			S_SEEK_CHK: begin
				if (mem_rdata == ST_SPLIT && lvl_q > tgt_q) begin
					n_q <= {n_q[NW-2:0], 1'b0};
					lvl_q <= lvl_q - OW'(1);
				end
			end
			S_BACK: begin
				if (n_q != ROOT) begin
					if (n_q[0]) begin
						n_q <= n_q >> 1;
						lvl_q <= lvl_q + OW'(1);
					end else begin
						n_q <= n_q + NW'(1);
					end
				end
			end
			S_SPLIT_B: begin
				n_q <= {n_q[NW-2:0], 1'b0};
				lvl_q <= lvl_q - OW'(1);
			end
			S_MRG_B: n_q <= n_q >> 1;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = res_q;
	assign prdata = base_q;
	assign pready = 1'b1;

	`BPA_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
	`BPA_NEVER(a_rw_clash, mem_we && mem_re && mem_waddr == mem_raddr,
		"node read and write collide")
	`BPA_ASSERT(a_err_zero,
		(done && result.error_code != ERR_OK) |-> (result.user_pointer == 32'd0),
		"failed beat carries a pointer")
	`BPA_NEVER(a_done_clear, done && $past(state_q) == S_CLEAR, "result during clearing pass")

endmodule
